// ===== design/tlik_pkg.sv =====
// shared types, constants and tables of the two-link inverse kinematics core
`timescale 1ns / 1ps
package tlik_pkg;

  localparam int X_W        = 15;
  localparam int Y_W        = 16;
  localparam int LINK_W     = 14;
  localparam int ANG_W      = 16;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_FIRST_LINK  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_LINK = 2'd1;
  localparam logic [LINK_W-1:0]    LINK_RESET      = 14'd2224;

  localparam int SQ_W       = 29;
  localparam int RAD_W      = 2 * SQ_W;
  localparam int OP_W       = 33;
  localparam int NORM_W     = 41;
  localparam int NORM_STEPS = 6;
  localparam int V_W        = 44;
  localparam int Z_W        = 27;
  localparam int Q_W        = Z_W + 1;
  localparam int TAB_LEN    = 24;
  localparam int DEF_CORDIC_STAGES = 16;

  localparam int HALF_PI_Q24 = 26353589;
  localparam int PI_Q24      = 52707179;
  localparam int PI_Q13      = 25736;
  localparam int ROUND_HALF  = 1024;
  localparam int ROUND_SHIFT = 11;

  localparam logic [Z_W-1:0] ATAN_TAB [TAB_LEN] = '{
    27'd13176795, 27'd7778716, 27'd4110060, 27'd2086331,
    27'd1047214,  27'd524117,  27'd262123,  27'd131069,
    27'd65536,    27'd32768,   27'd16384,   27'd8192,
    27'd4096,     27'd2048,    27'd1024,    27'd512,
    27'd256,      27'd128,     27'd64,      27'd32,
    27'd16,       27'd8,       27'd4,       27'd2
  };

  typedef struct packed {
    logic [X_W-1:0]  x;
    logic [Y_W-1:0]  ymag;
    logic            y_neg;
    logic            y_zero;
    logic [SQ_W-1:0] nmag;
    logic            num_neg;
    logic            num_zero;
    logic [OP_W-1:0] d2mag;
    logic            d2_neg;
    logic            d2_zero;
    logic            unreach;
  } side_t;

endpackage

// ===== design/two_link_inverse_kinematics_core.sv =====
// two-link planar inverse kinematics, elbow-down solution, fully pipelined
//
//   channel   | direction | handshake            | payload
//   s_axis    | in        | tvalid / tready      | tdata: horizontal_reach, vertical_offset
//   m_axis    | out       | tvalid / tready      | tdata: shoulder_angle, elbow_angle; tuser: unreachable
//   cfg       | in        | cfg_valid / cfg_ready| cfg_index, cfg_data (link lengths)
//
// one transaction per cycle while m_axis is not stalled; the pipeline runs through the
// input stages, the 29-cell square root row, the 6-step normalizer and the cordic cell row
// a stall on m_axis freezes the whole pipeline and drops s_axis_tready_o
// reset clears all valid bits and loads both link lengths with 2224
// cfg writes are always taken and apply to transactions accepted afterwards
`timescale 1ns / 1ps
module two_link_inverse_kinematics_core #(
  parameter int CORDIC_STAGES = tlik_pkg::DEF_CORDIC_STAGES
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // horizontal_reach [14:0], vertical_offset [30:15], zero [31]
  input  logic [31:0]                      s_axis_tdata_i,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // shoulder_angle [15:0], elbow_angle [31:16]
  output logic [31:0]                      m_axis_tdata_o,
  // unreachable [0]
  output logic                             m_axis_tuser_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [tlik_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [tlik_pkg::LINK_W-1:0]      cfg_data_i
);
  import tlik_pkg::*;

  logic adv;

  // link length registers
  logic [LINK_W-1:0] link1_q, link2_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link1_q <= LINK_RESET;
      link2_q <= LINK_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_FIRST_LINK:  link1_q <= cfg_data_i;
        REG_SECOND_LINK: link2_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // stage 1: squares and link product
  logic [X_W-1:0]        x_in;
  logic signed [Y_W-1:0] y_in;
  side_t                 side1_d;
  logic                  v1_q, v2_q, v3_q, v4_q, v5_q, v6_q;
  side_t                 side1_q, side2_q, side3_q, side4_q, side5_q, side6_q;
  logic [29:0]           xx1_q;
  logic [30:0]           yy1_q;
  logic [27:0]           aa1_q, ab1_q, p1_q;

  assign x_in = s_axis_tdata_i[X_W-1:0];
  assign y_in = $signed(s_axis_tdata_i[X_W+Y_W-1:X_W]);

  always_comb begin
    side1_d        = '0;
    side1_d.x      = x_in;
    side1_d.y_neg  = y_in[Y_W-1];
    side1_d.y_zero = (y_in == '0);
    side1_d.ymag   = y_in[Y_W-1] ? Y_W'(-y_in) : Y_W'(y_in);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side1_q <= side1_d;
      xx1_q   <= 30'(x_in) * 30'(x_in);
      yy1_q   <= 31'(side1_d.ymag) * 31'(side1_d.ymag);
      aa1_q   <= 28'(link1_q) * 28'(link1_q);
      ab1_q   <= 28'(link2_q) * 28'(link2_q);
      p1_q    <= 28'(link1_q) * 28'(link2_q);
    end
  end

  // stage 2: partial sums
  logic [31:0]        r2_2_q;
  logic [28:0]        s12_2_q, den2_q;
  logic signed [28:0] dif2_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side2_q <= side1_q;
      r2_2_q  <= 32'(xx1_q) + 32'(yy1_q);
      s12_2_q <= 29'(aa1_q) + 29'(ab1_q);
      dif2_q  <= $signed({1'b0, aa1_q}) - $signed({1'b0, ab1_q});
      den2_q  <= {p1_q, 1'b0};
    end
  end

  // stage 3: cosine numerator and second-term divisor
  logic signed [33:0] num3_q, d2_3_q;
  logic [28:0]        den3_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side3_q <= side2_q;
      num3_q  <= $signed({2'b00, r2_2_q}) - $signed({5'b00000, s12_2_q});
      d2_3_q  <= $signed({2'b00, r2_2_q}) + $signed({{5{dif2_q[28]}}, dif2_q});
      den3_q  <= den2_q;
    end
  end

  // stage 4: reach check and magnitudes
  logic signed [33:0] den34, nabs, d2abs;
  side_t              side4_d;
  logic [28:0]        den4_q;

  assign den34 = $signed({5'b00000, den3_q});
  assign nabs  = num3_q[33] ? -num3_q : num3_q;
  assign d2abs = d2_3_q[33] ? -d2_3_q : d2_3_q;

  always_comb begin
    side4_d          = side3_q;
    side4_d.nmag     = nabs[SQ_W-1:0];
    side4_d.num_neg  = num3_q[33];
    side4_d.num_zero = (num3_q == '0);
    side4_d.d2mag    = d2abs[OP_W-1:0];
    side4_d.d2_neg   = d2_3_q[33];
    side4_d.d2_zero  = (d2_3_q == '0);
    side4_d.unreach  = (den3_q == '0) || (num3_q > den34) || (num3_q < -den34);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side4_q <= side4_d;
      den4_q  <= den3_q;
    end
  end

  // stage 5 and 6: radicand den^2 - num^2
  logic [RAD_W-1:0] dd5_q, nn5_q, rad6_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side5_q <= side4_q;
      dd5_q   <= RAD_W'(den4_q) * RAD_W'(den4_q);
      nn5_q   <= RAD_W'(side4_q.nmag) * RAD_W'(side4_q.nmag);
      side6_q <= side5_q;
      rad6_q  <= dd5_q - nn5_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else if (adv) begin
      v1_q <= s_axis_tvalid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
    end
  end

  // square root cell row
  logic             sv_w   [SQ_W+1];
  logic [RAD_W-1:0] srem_w [SQ_W+1];
  logic [SQ_W-1:0]  sroot_w[SQ_W+1];
  side_t            sside_w[SQ_W+1];

  assign sv_w[0]    = v6_q;
  assign srem_w[0]  = rad6_q;
  assign sroot_w[0] = '0;
  assign sside_w[0] = side6_q;

  genvar b;
  generate
    for (b = 0; b < SQ_W; b++) begin : g_sqrt
      tlik_sqrt_cell #(
        .BIT (SQ_W - 1 - b)
      ) u_sqrt (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .en_i    (adv),
        .valid_i (sv_w[b]),
        .rem_i   (srem_w[b]),
        .root_i  (sroot_w[b]),
        .side_i  (sside_w[b]),
        .valid_o (sv_w[b+1]),
        .rem_o   (srem_w[b+1]),
        .root_o  (sroot_w[b+1]),
        .side_o  (sside_w[b+1])
      );
    end
  endgenerate

  // three arctangent units
  logic [SQ_W-1:0]       s_root;
  side_t                 s_side;
  logic                  va, vb, vc;
  logic signed [Z_W-1:0] ra, rb, rc;
  logic [2:0]            ta, tb, tc;

  assign s_root = sroot_w[SQ_W];
  assign s_side = sside_w[SQ_W];

  tlik_atan #(
    .STAGES (CORDIC_STAGES),
    .SIDE_W (3)
  ) u_atan_elbow (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (sv_w[SQ_W]),
    .n_i     (OP_W'(s_root)),
    .d_i     (OP_W'(s_side.nmag)),
    .side_i  ({s_side.unreach, s_side.num_neg, s_side.num_zero}),
    .valid_o (va),
    .z_o     (ra),
    .side_o  (ta)
  );

  tlik_atan #(
    .STAGES (CORDIC_STAGES),
    .SIDE_W (3)
  ) u_atan_target (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (sv_w[SQ_W]),
    .n_i     (OP_W'(s_side.ymag)),
    .d_i     (OP_W'(s_side.x)),
    .side_i  ({(s_side.x == '0), s_side.y_neg, s_side.y_zero}),
    .valid_o (vb),
    .z_o     (rb),
    .side_o  (tb)
  );

  tlik_atan #(
    .STAGES (CORDIC_STAGES),
    .SIDE_W (3)
  ) u_atan_offset (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (sv_w[SQ_W]),
    .n_i     (OP_W'(s_root)),
    .d_i     (s_side.d2mag),
    .side_i  ({(s_root == '0), s_side.d2_zero, s_side.d2_neg}),
    .valid_o (vc),
    .z_o     (rc),
    .side_o  (tc)
  );

  // quadrant fix-up and sum
  logic signed [Q_W-1:0] hp, pi, ra_e, rb_e, rc_e, acos_v, b_term, c_term;
  logic signed [Q_W-1:0] q1_q, q2_q;
  logic                  fv_q, funr_q;

  assign hp   = $signed(Q_W'(HALF_PI_Q24));
  assign pi   = $signed(Q_W'(PI_Q24));
  assign ra_e = Q_W'(ra);
  assign rb_e = Q_W'(rb);
  assign rc_e = Q_W'(rc);

  always_comb begin
    if (ta[0]) begin
      acos_v = hp;
    end else if (ta[1]) begin
      acos_v = pi - ra_e;
    end else begin
      acos_v = ra_e;
    end
    if (tb[2]) begin
      b_term = tb[1] ? -hp : (tb[0] ? '0 : hp);
    end else begin
      b_term = tb[1] ? -rb_e : rb_e;
    end
    if (tc[2]) begin
      c_term = '0;
    end else if (tc[1]) begin
      c_term = -hp;
    end else begin
      c_term = tc[0] ? rc_e : -rc_e;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      q1_q   <= b_term + c_term;
      q2_q   <= -acos_v;
      funr_q <= ta[2];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q <= 1'b0;
    end else if (adv) begin
      fv_q <= va & vb & vc;
    end
  end

  // rounding to q13, saturation and output register
  logic signed [Q_W-1:0]   r1, r2, pi13;
  logic signed [ANG_W-1:0] sh_d, el_d;
  logic                    m_valid_q, unr_q;
  logic [ANG_W-1:0]        sh_q, el_q;

  assign pi13 = $signed(Q_W'(PI_Q13));
  assign r1   = (q1_q + $signed(Q_W'(ROUND_HALF))) >>> ROUND_SHIFT;
  assign r2   = (q2_q + $signed(Q_W'(ROUND_HALF))) >>> ROUND_SHIFT;

  always_comb begin
    if (r1 > pi13) begin
      sh_d = ANG_W'(pi13);
    end else if (r1 < -pi13) begin
      sh_d = ANG_W'(-pi13);
    end else begin
      sh_d = ANG_W'(r1);
    end
    if (r2 > pi13) begin
      el_d = ANG_W'(pi13);
    end else if (r2 < -pi13) begin
      el_d = ANG_W'(-pi13);
    end else begin
      el_d = ANG_W'(r2);
    end
    if (funr_q) begin
      sh_d = '0;
      el_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (adv) begin
      m_valid_q <= fv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sh_q  <= sh_d;
      el_q  <= el_d;
      unr_q <= funr_q;
    end
  end

  assign adv             = !m_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = adv;
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {el_q, sh_q};
  assign m_axis_tuser_o  = unr_q;

  // checks
  a_unreach_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o) |-> (m_axis_tdata_o == '0))
    else $error("unreachable result carries nonzero angles");

  a_elbow_sign : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> ($signed(m_axis_tdata_o[2*ANG_W-1:ANG_W]) <= 0))
    else $error("elbow angle positive");

  a_shoulder_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (($signed(m_axis_tdata_o[ANG_W-1:0]) <= $signed(ANG_W'(PI_Q13)))
                      && ($signed(m_axis_tdata_o[ANG_W-1:0]) >= -$signed(ANG_W'(PI_Q13)))))
    else $error("shoulder angle out of range");

  a_stall_blocks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |-> !s_axis_tready_o)
    else $error("input taken while output stalled");
endmodule

// ===== design/tlik_sqrt_cell.sv =====
// one restoring square root cell, settles a single root bit
`timescale 1ns / 1ps
module tlik_sqrt_cell #(
  parameter int BIT = 0
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [tlik_pkg::RAD_W-1:0]  rem_i,
  input  logic [tlik_pkg::SQ_W-1:0]   root_i,
  input  tlik_pkg::side_t             side_i,
  output logic                        valid_o,
  output logic [tlik_pkg::RAD_W-1:0]  rem_o,
  output logic [tlik_pkg::SQ_W-1:0]   root_o,
  output tlik_pkg::side_t             side_o
);
  import tlik_pkg::*;

  logic [RAD_W-1:0] trial;
  logic             fits;
  logic             valid_q;
  logic [RAD_W-1:0] rem_q, rem_d;
  logic [SQ_W-1:0]  root_q, root_d;
  side_t            side_q;

  assign trial = (RAD_W'(root_i) << (BIT + 1)) | (RAD_W'(1) << (2 * BIT));
  assign fits  = (rem_i >= trial);

  always_comb begin
    rem_d  = rem_i;
    root_d = root_i;
    if (fits) begin
      rem_d  = rem_i - trial;
      root_d = root_i | (SQ_W'(1) << BIT);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      root_q <= root_d;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign root_o  = root_q;
  assign side_o  = side_q;
endmodule

// ===== design/tlik_cordic_cell.sv =====
// one vectoring cordic cell with its fixed shift and angle step
`timescale 1ns / 1ps
module tlik_cordic_cell #(
  parameter int IDX    = 0,
  parameter int SIDE_W = 1
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  logic                             valid_i,
  input  logic signed [tlik_pkg::V_W-1:0]  vx_i,
  input  logic signed [tlik_pkg::V_W-1:0]  vy_i,
  input  logic signed [tlik_pkg::Z_W-1:0]  z_i,
  input  logic [SIDE_W-1:0]                side_i,
  output logic                             valid_o,
  output logic signed [tlik_pkg::V_W-1:0]  vx_o,
  output logic signed [tlik_pkg::V_W-1:0]  vy_o,
  output logic signed [tlik_pkg::Z_W-1:0]  z_o,
  output logic [SIDE_W-1:0]                side_o
);
  import tlik_pkg::*;

  logic signed [V_W-1:0] dx, dy;
  logic signed [Z_W-1:0] step;
  logic                  pos;
  logic                  valid_q;
  logic signed [V_W-1:0] vx_q, vx_d, vy_q, vy_d;
  logic signed [Z_W-1:0] z_q, z_d;
  logic [SIDE_W-1:0]     side_q;

  assign dx   = vy_i >>> IDX;
  assign dy   = vx_i >>> IDX;
  assign step = $signed(ATAN_TAB[IDX]);
  assign pos  = !vy_i[V_W-1] && (vy_i != '0);

  always_comb begin
    if (pos) begin
      vx_d = vx_i + dx;
      vy_d = vy_i - dy;
      z_d  = z_i + step;
    end else begin
      vx_d = vx_i - dx;
      vy_d = vy_i + dy;
      z_d  = z_i - step;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      vx_q   <= vx_d;
      vy_q   <= vy_d;
      z_q    <= z_d;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign vx_o    = vx_q;
  assign vy_o    = vy_q;
  assign z_o     = z_q;
  assign side_o  = side_q;
endmodule

// ===== design/tlik_atan.sv =====
// first-quadrant arctangent: normalizing shifter followed by a row of cordic cells
`timescale 1ns / 1ps
module tlik_atan #(
  parameter int STAGES = tlik_pkg::DEF_CORDIC_STAGES,
  parameter int SIDE_W = 1
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  logic                             valid_i,
  input  logic [tlik_pkg::OP_W-1:0]        n_i,
  input  logic [tlik_pkg::OP_W-1:0]        d_i,
  input  logic [SIDE_W-1:0]                side_i,
  output logic                             valid_o,
  output logic signed [tlik_pkg::Z_W-1:0]  z_o,
  output logic [SIDE_W-1:0]                side_o
);
  import tlik_pkg::*;

  localparam int TW = SIDE_W + 1;

  logic              nv_q [NORM_STEPS];
  logic [NORM_W-1:0] nn_q [NORM_STEPS];
  logic [NORM_W-1:0] nd_q [NORM_STEPS];
  logic [NORM_W-1:0] nm_q [NORM_STEPS];
  logic [TW-1:0]     nt_q [NORM_STEPS];

  logic                  cv_w [STAGES+1];
  logic signed [V_W-1:0] cx_w [STAGES+1];
  logic signed [V_W-1:0] cy_w [STAGES+1];
  logic signed [Z_W-1:0] cz_w [STAGES+1];
  logic [TW-1:0]         ct_w [STAGES+1];

  genvar k;
  generate
    for (k = 0; k < NORM_STEPS; k++) begin : g_norm
      localparam int SH = 1 << (NORM_STEPS - 1 - k);
      logic              v_in;
      logic [NORM_W-1:0] n_in, d_in, m_in;
      logic [TW-1:0]     t_in;
      logic              sh;
      if (k == 0) begin : g_first
        assign v_in = valid_i;
        assign n_in = NORM_W'(n_i);
        assign d_in = NORM_W'(d_i);
        assign m_in = (n_i > d_i) ? NORM_W'(n_i) : NORM_W'(d_i);
        assign t_in = {(n_i == '0), side_i};
      end else begin : g_next
        assign v_in = nv_q[k-1];
        assign n_in = nn_q[k-1];
        assign d_in = nd_q[k-1];
        assign m_in = nm_q[k-1];
        assign t_in = nt_q[k-1];
      end
      assign sh = (m_in[NORM_W-1 -: SH] == '0);

      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          nv_q[k] <= 1'b0;
        end else if (en_i) begin
          nv_q[k] <= v_in;
        end
      end

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          nn_q[k] <= sh ? (n_in << SH) : n_in;
          nd_q[k] <= sh ? (d_in << SH) : d_in;
          nm_q[k] <= sh ? (m_in << SH) : m_in;
          nt_q[k] <= t_in;
        end
      end
    end
  endgenerate

  assign cv_w[0] = nv_q[NORM_STEPS-1];
  assign cx_w[0] = $signed(V_W'(nd_q[NORM_STEPS-1]));
  assign cy_w[0] = $signed(V_W'(nn_q[NORM_STEPS-1]));
  assign cz_w[0] = '0;
  assign ct_w[0] = nt_q[NORM_STEPS-1];

  genvar i;
  generate
    for (i = 0; i < STAGES; i++) begin : g_cell
      tlik_cordic_cell #(
        .IDX    (i),
        .SIDE_W (TW)
      ) u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .en_i    (en_i),
        .valid_i (cv_w[i]),
        .vx_i    (cx_w[i]),
        .vy_i    (cy_w[i]),
        .z_i     (cz_w[i]),
        .side_i  (ct_w[i]),
        .valid_o (cv_w[i+1]),
        .vx_o    (cx_w[i+1]),
        .vy_o    (cy_w[i+1]),
        .z_o     (cz_w[i+1]),
        .side_o  (ct_w[i+1])
      );
    end
  endgenerate

  assign valid_o = cv_w[STAGES];
  assign z_o     = ct_w[STAGES][SIDE_W] ? '0 : cz_w[STAGES];
  assign side_o  = ct_w[STAGES][SIDE_W-1:0];
endmodule

// ===== tb/two_link_inverse_kinematics_core_test.sv =====
// testbench of the two-link inverse kinematics core: self-checking scoreboard with own predictor
`timescale 1ns / 1ps
module two_link_inverse_kinematics_core_test;
  import tlik_pkg::*;

  localparam int STAGES = DEF_CORDIC_STAGES;
  localparam int SETTLE = 43 + STAGES + 20;

  typedef struct {
    logic signed [ANG_W-1:0] shoulder;
    logic signed [ANG_W-1:0] elbow;
    logic                    unreach;
  } joint_angles_t;

  class ik_scoreboard;
    longint        link1 = LINK_RESET;
    longint        link2 = LINK_RESET;
    joint_angles_t pending[$];
    int            errors = 0;

    function void set_link(logic [CFG_IDX_W-1:0] idx, logic [LINK_W-1:0] val);
      if (idx == REG_FIRST_LINK) link1 = val;
      else if (idx == REG_SECOND_LINK) link2 = val;
    endfunction

    function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned root, bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
        if (v >= root + bitv) begin
          v -= root + bitv;
          root = (root >> 1) + bitv;
        end else begin
          root >>= 1;
        end
        bitv >>= 2;
      end
      return root;
    endfunction

    function longint atan_pos(longint unsigned n, longint unsigned d);
      longint unsigned m;
      longint vx, vy, z, dx, dy;
      z = 0;
      if (n == 0) return 0;
      m = (n > d) ? n : d;
      while (m < (64'd1 << 40)) begin
        m <<= 1;
        n <<= 1;
        d <<= 1;
      end
      vx = d;
      vy = n;
      for (int i = 0; i < STAGES && i < TAB_LEN; i++) begin
        dx = vy >>> i;
        dy = vx >>> i;
        if (vy > 0) begin
          vx += dx;
          vy -= dy;
          z += longint'(ATAN_TAB[i]);
        end else begin
          vx -= dx;
          vy += dy;
          z -= longint'(ATAN_TAB[i]);
        end
      end
      return z;
    endfunction

    function longint atan_signed(longint n, longint d);
      longint r;
      if (d == 0) return (n > 0) ? HALF_PI_Q24 : ((n < 0) ? -HALF_PI_Q24 : 0);
      r = atan_pos((n < 0) ? -n : n, (d < 0) ? -d : d);
      return ((n < 0) != (d < 0)) ? -r : r;
    endfunction

    function logic signed [ANG_W-1:0] round_q13(longint v);
      longint q;
      q = (v + ROUND_HALF) >>> ROUND_SHIFT;
      if (q > PI_Q13) q = PI_Q13;
      if (q < -PI_Q13) q = -PI_Q13;
      return q[ANG_W-1:0];
    endfunction

    function void note_target(logic [X_W-1:0] xr, logic signed [Y_W-1:0] yr);
      longint x, y, r2, num, den, s, acos_v;
      joint_angles_t exp_a;
      x = xr;
      y = yr;
      r2 = x * x + y * y;
      num = r2 - link1 * link1 - link2 * link2;
      den = 2 * link1 * link2;
      if (den == 0 || num > den || num < -den) begin
        exp_a = '{'0, '0, 1'b1};
      end else begin
        s = int_sqrt(den * den - num * num);
        if (num > 0) acos_v = atan_pos(s, num);
        else if (num == 0) acos_v = HALF_PI_Q24;
        else acos_v = PI_Q24 - atan_pos(s, -num);
        exp_a.elbow = round_q13(-acos_v);
        exp_a.shoulder = round_q13(atan_signed(y, x) +
                                   atan_signed(-s, r2 + link1 * link1 - link2 * link2));
        exp_a.unreach = 1'b0;
      end
      pending.push_back(exp_a);
    endfunction

    function void check_angles(logic [31:0] data, logic flag);
      joint_angles_t e;
      if (pending.size() == 0) begin
        $display("%0t: result with nothing expected: tdata=%h tuser=%b", $time, data, flag);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (data[15:0] !== e.shoulder) begin
        $display("%0t: shoulder expected %0d actual %0d", $time, e.shoulder,
                 $signed(data[15:0]));
        errors++;
      end
      if (data[31:16] !== e.elbow) begin
        $display("%0t: elbow expected %0d actual %0d", $time, e.elbow,
                 $signed(data[31:16]));
        errors++;
      end
      if (flag !== e.unreach) begin
        $display("%0t: unreachable expected %b actual %b", $time, e.unreach, flag);
        errors++;
      end
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid_i = 1'b0;
  logic                 s_axis_tready_o;
  logic [31:0]          s_axis_tdata_i = '0;
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i = 1'b0;
  logic [31:0]          m_axis_tdata_o;
  logic                 m_axis_tuser_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [LINK_W-1:0]    cfg_data_i = '0;

  ik_scoreboard sb = new();
  int           stall_mode = 0;

  two_link_inverse_kinematics_core #(.CORDIC_STAGES(STAGES)) dut (.*);

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #4ms;
    $display("two_link_inverse_kinematics_core_test: FAIL");
    $finish;
  end

  always @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o)
      sb.note_target(s_axis_tdata_i[14:0], s_axis_tdata_i[30:15]);
    if (m_axis_tvalid_o && m_axis_tready_i)
      sb.check_angles(m_axis_tdata_o, m_axis_tuser_o);
    if (cfg_valid_i && cfg_ready_o)
      sb.set_link(cfg_index_i, cfg_data_i);
  end

  // receiver stall pattern
  always @(negedge clk_i) begin
    if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 2);
    case (stall_mode)
      0: m_axis_tready_i = 1'b1;
      1: m_axis_tready_i = 1'($urandom_range(0, 1));
      default: m_axis_tready_i = ($urandom_range(0, 3) == 0);
    endcase
  end

  // called at a falling edge, returns at a falling edge with tvalid still high
  task automatic send_target(logic [X_W-1:0] x, logic signed [Y_W-1:0] y);
    s_axis_tvalid_i = 1'b1;
    s_axis_tdata_i = {1'b0, y, x};
    do @(posedge clk_i); while (!(s_axis_tvalid_i && s_axis_tready_o));
    @(negedge clk_i);
  endtask

  task automatic pause_sender(int cycles);
    s_axis_tvalid_i = 1'b0;
    repeat (cycles) @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid_i = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [LINK_W-1:0] val);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = val;
    do @(posedge clk_i); while (!(cfg_valid_i && cfg_ready_o));
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic set_links(logic [LINK_W-1:0] l1, logic [LINK_W-1:0] l2);
    drain();
    write_reg(REG_FIRST_LINK, l1);
    write_reg(REG_SECOND_LINK, l2);
  endtask

  task automatic random_targets(int count);
    int burst;
    int reach;
    int x, y;
    burst = 0;
    for (int n = 0; n < count; n++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 20);
        if ($urandom_range(0, 1)) pause_sender($urandom_range(1, 10));
      end
      burst--;
      reach = int'(sb.link1 + sb.link2);
      if (reach > 32767) reach = 32767;
      if ($urandom_range(0, 4) == 0) begin
        x = $urandom_range(0, 32767);
        y = $urandom_range(0, 65535) - 32768;
      end else begin
        x = $urandom_range(0, reach);
        y = $urandom_range(0, 2 * reach) - reach;
      end
      send_target(X_W'(x), Y_W'(y));
    end
  endtask

  initial begin
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed targets under the reset links
    send_target(15'd0, 16'sd0);
    send_target(15'd0, 16'sd100);
    send_target(15'd0, -16'sd100);
    send_target(15'd4448, 16'sd0);
    send_target(15'd4449, 16'sd0);
    send_target(15'd3000, 16'sd1500);
    send_target(15'd1000, -16'sd2000);
    send_target(15'h7fff, 16'sh7fff);
    send_target(15'h7fff, -16'sh8000);
    send_target(15'h5555, 16'sh2aaa);
    send_target(15'h2aaa, -16'sh5556);
    set_links(14'd3, 14'd4);
    send_target(15'd3, 16'sd4);
    send_target(15'd5, 16'sd0);
    send_target(15'd7, 16'sd0);
    send_target(15'd1, 16'sd0);
    send_target(15'd0, -16'sd1);
    send_target(15'd3, -16'sd4);
    // out-of-range register indexes are ignored
    drain();
    write_reg(2'd2, 14'd77);
    write_reg(2'd3, 14'd5);
    send_target(15'd4, 16'sd3);
    set_links(14'd0, 14'd100);
    send_target(15'd50, 16'sd50);
    set_links(14'd16383, 14'd1);
    send_target(15'd16382, 16'sd0);
    send_target(15'd16384, 16'sd0);

    set_links(14'd2224, 14'd2224);
    random_targets(150);
    // let the pipeline empty before going on
    drain();
    random_targets(50);
    set_links(14'd1, 14'd1);
    random_targets(40);
    set_links(14'd16383, 14'd16383);
    random_targets(80);
    set_links(14'd5000, 14'd3000);
    random_targets(80);
    set_links(LINK_W'($urandom_range(1, 16383)), LINK_W'($urandom_range(1, 16383)));
    random_targets(80);
    set_links(14'h2aaa, 14'h1555);
    random_targets(30);
    drain();

    if (sb.errors == 0) begin
      $display("two_link_inverse_kinematics_core_test: PASS");
    end else begin
      $display("two_link_inverse_kinematics_core_test: FAIL");
    end
    $finish;
  end
endmodule

// ===== two_link_inverse_kinematics_core.f =====
design/tlik_pkg.sv
design/tlik_sqrt_cell.sv
design/tlik_cordic_cell.sv
design/tlik_atan.sv
design/two_link_inverse_kinematics_core.sv
tb/two_link_inverse_kinematics_core_test.sv
